@@ hw/rtl/blwc_pkg.sv @@
// ----------------------------------------------------------------------------
// blwc_pkg
// shared types and constants of the byte lane and wide checksum block
// ----------------------------------------------------------------------------
package blwc_pkg;

	localparam int unsigned LANES      = 8;
	localparam int unsigned LANE_BITS  = 3;
	localparam int unsigned ASM_BITS   = 56;
	localparam int unsigned WIDE_BITS  = 64;
	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned IDX_BITS   = 4;

	// word index codes during a drain
	localparam logic [IDX_BITS-1:0] IDX_FIRST_LANE = 4'd0;
	localparam logic [IDX_BITS-1:0] IDX_WIDE_HI    = 4'd8;
	localparam logic [IDX_BITS-1:0] IDX_WIDE_LO    = 4'd9;

	// runs that may have ended without being fully drained
	localparam logic [1:0] MAX_JOBS = 2'd2;

	typedef struct packed {
		logic [WORD_BITS-1:0] sum_word;
		logic                 bad_offset;
		logic                 last_word;
	} item_t;

endpackage

@@ hw/rtl/blwc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// blwc_out_fifo
// two-entry result queue between the drain reader and the output stream
// ----------------------------------------------------------------------------
module blwc_out_fifo
	import blwc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  item_t      push_item,
	input  logic       pop_ready,
	output logic       out_valid,
	output item_t      out_item,
	output logic [1:0] level
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot_q[rd_ptr_q];
	assign level     = cnt_q;
	assign pop       = out_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ hw/rtl/byte_lane_and_wide_checksum.sv @@
// ----------------------------------------------------------------------------
// byte_lane_and_wide_checksum
// eight byte-lane 32-bit sums and a 64-bit big-endian word sum over a byte
// stream, with a zeroed window, ten result words per image (one word for a
// run with a bad offset)
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  -----------------------------------------
//  s_*      in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
//  m_*      out  m_tvalid/m_tready  m_tdata = sum_word, m_tuser = bad_offset,
//                                   m_tlast = last_word
//  cfg_*    in   cfg_wr_en          cfg_wr_data = mask_offset
//
//  one image byte per cycle while s_tready is high; the lane sums live in a 16 x 32 memory (two
//  banks, one per run) with a registered read, updated read-modify-write
//  a run's results come out at one word per cycle after its last byte while m_tready stays high
//  s_tready drops only while two ended runs still wait to be drained
//  reset is asynchronous and clears all control state and the running sums;
//  no clearing pass: per-entry valid bits stand for the zeroed lane sums
//  m_tready low holds back the drain reader, never the byte path directly
//
module byte_lane_and_wide_checksum
	import blwc_pkg::*;
#(
	parameter int unsigned MASK_LENGTH   = 40,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,   // mask_offset
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] data_byte
	input  logic        s_tlast,       // last_byte
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,       // [31:0] sum_word
	output logic        m_tuser,       // [0] bad_offset
	output logic        m_tlast        // last_word
);

	localparam int unsigned ADDR_BITS = LANE_BITS + 1;
	localparam int unsigned CMP_BITS  = 33;

	// configuration
	logic [31:0] mask_offset_q;

	// running state of the current run
	logic [POSITION_BITS-1:0] pos_q;
	logic [WIDE_BITS-1:0]     wide_q;
	logic [ASM_BITS-1:0]      asm_q;
	logic                     cur_q;      // bank of the current run

	// per-bank results of ended runs
	logic [WIDE_BITS-1:0] wide_res_q [2];
	logic                 bad_res_q  [2];

	// lane sum memory and its valid bits
	logic [WORD_BITS-1:0]   lane_mem [2*LANES];
	logic [2*LANES-1:0]     vld_q;

	// byte pipeline
	logic                   acc;
	logic [LANE_BITS-1:0]   lane;
	logic [CMP_BITS-1:0]    pos_c;
	logic [CMP_BITS-1:0]    start_c;
	logic [CMP_BITS-1:0]    end_c;
	logic                   in_win;
	logic [7:0]             byte_v;
	logic [WIDE_BITS-1:0]   word;
	logic [WIDE_BITS-1:0]   addend;
	logic [WIDE_BITS-1:0]   wide_nxt;
	logic                   bad_now;

	logic                   valid_s1;
	logic                   last_s1;
	logic [ADDR_BITS-1:0]   addr_s1;
	logic [7:0]             byte_s1;
	logic [WORD_BITS-1:0]   rd_s1;
	logic [WORD_BITS-1:0]   lane_new;

	// run bookkeeping
	logic [1:0]             jobs_q;     // ended runs not yet retired
	logic [1:0]             rdy_q;      // ended runs whose writes have landed

	// drain reader
	logic                   drain_act_q;
	logic                   dr_bank_q;
	logic [IDX_BITS-1:0]    dr_idx_q;
	logic                   start;
	logic                   issue;
	logic                   d1_valid_q;
	logic                   d1_bank_q;
	logic [IDX_BITS-1:0]    d1_idx_q;
	logic [WORD_BITS-1:0]   rd_d1;
	logic                   retire;
	item_t                  d1_item;
	item_t                  out_item;
	logic [1:0]             fifo_level;
	logic [2:0]             occ;
	logic                   pop;

	// ---------------- byte path, first stage ----------------
	assign s_tready = (jobs_q < MAX_JOBS);
	assign acc      = s_tvalid && s_tready;
	assign lane     = pos_q[LANE_BITS-1:0];

	// window test without wrap on 33 bits
	assign pos_c   = CMP_BITS'(pos_q);
	assign start_c = CMP_BITS'(mask_offset_q);
	assign end_c   = start_c + CMP_BITS'(MASK_LENGTH);
	assign in_win  = (pos_c >= start_c) && (pos_c < end_c);
	assign byte_v  = in_win ? 8'd0 : s_tdata;
	assign bad_now = (end_c > (pos_c + CMP_BITS'(1)));

	// big-endian word; a partial group is left-aligned (zero low bytes)
	assign word = {asm_q, byte_v};
	always_comb begin
		if (lane == LANE_BITS'(LANES - 1)) begin
			addend = word;
		end else if (s_tlast) begin
			addend = word << {~lane, 3'b000};
		end else begin
			addend = '0;
		end
	end
	assign wide_nxt = wide_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_offset_q <= '0;
			pos_q         <= '0;
			wide_q        <= '0;
			asm_q         <= '0;
			cur_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mask_offset_q <= cfg_wr_data;
			end
			if (acc) begin
				if (s_tlast) begin
					pos_q  <= '0;
					wide_q <= '0;
					asm_q  <= '0;
					cur_q  <= ~cur_q;
				end else begin
					pos_q  <= pos_q + POSITION_BITS'(1);
					wide_q <= wide_nxt;
					asm_q  <= (lane == LANE_BITS'(LANES - 1)) ? '0 : word[ASM_BITS-1:0];
				end
			end
		end
	end

	// final sums of a run, kept per bank until drained
	always_ff @(posedge clk) begin
		if (acc && s_tlast) begin
			wide_res_q[cur_q] <= wide_nxt;
			bad_res_q[cur_q]  <= bad_now;
		end
	end

	// ---------------- lane memory ----------------
	// port a: lane read for update, port b: drain read, one write port
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= lane_mem[{cur_q, lane}];
		end
		if (issue) begin
			rd_d1 <= lane_mem[{dr_bank_q, dr_idx_q[LANE_BITS-1:0]}];
		end
		if (valid_s1) begin
			lane_mem[addr_s1] <= lane_new;
		end
	end

	// same lane recurs only eight bytes later, and each run owns its bank,
	// so the write of stage two never races a read of the same entry
	assign lane_new = (vld_q[addr_s1] ? rd_s1 : '0) + WORD_BITS'(byte_s1);

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= {cur_q, lane};
			byte_s1 <= byte_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			vld_q    <= '0;
		end else begin
			valid_s1 <= acc;
			last_s1  <= acc && s_tlast;
			// a bank is cleared as its drain retires, then set entry by entry
			for (int i = 0; i < 2*LANES; i++) begin
				if (retire && (ADDR_BITS'(i) >> LANE_BITS) == ADDR_BITS'(d1_bank_q)) begin
					vld_q[i] <= 1'b0;
				end else if (valid_s1 && addr_s1 == ADDR_BITS'(i)) begin
					vld_q[i] <= 1'b1;
				end
			end
		end
	end

	// ---------------- drain reader ----------------
	assign pop    = m_tvalid && m_tready;
	assign occ    = {1'b0, fifo_level} + {2'b00, d1_valid_q};
	assign start  = !drain_act_q && (rdy_q != 2'd0);
	assign issue  = drain_act_q && ((occ - {2'b00, pop}) <= 3'd1);
	assign retire = d1_valid_q && (d1_idx_q == IDX_WIDE_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_q      <= '0;
			rdy_q       <= '0;
			drain_act_q <= 1'b0;
			dr_bank_q   <= 1'b0;
			dr_idx_q    <= IDX_FIRST_LANE;
			d1_valid_q  <= 1'b0;
		end else begin
			jobs_q <= jobs_q + {1'b0, acc && s_tlast} - {1'b0, retire};
			rdy_q  <= rdy_q + {1'b0, last_s1} - {1'b0, start};
			d1_valid_q <= issue;
			if (start) begin
				drain_act_q <= 1'b1;
				// an error run skips straight to its single word
				dr_idx_q    <= bad_res_q[dr_bank_q] ? IDX_WIDE_LO : IDX_FIRST_LANE;
			end else if (issue) begin
				if (dr_idx_q == IDX_WIDE_LO) begin
					drain_act_q <= 1'b0;
					dr_bank_q   <= ~dr_bank_q;
				end else begin
					dr_idx_q <= dr_idx_q + IDX_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			d1_bank_q <= dr_bank_q;
			d1_idx_q  <= dr_idx_q;
		end
	end

	// build the result word from memory or the saved wide sum
	always_comb begin
		d1_item.bad_offset = 1'b0;
		d1_item.last_word  = 1'b0;
		if (d1_idx_q == IDX_WIDE_HI) begin
			d1_item.sum_word = wide_res_q[d1_bank_q][WIDE_BITS-1:WORD_BITS];
		end else if (d1_idx_q == IDX_WIDE_LO) begin
			d1_item.last_word = 1'b1;
			if (bad_res_q[d1_bank_q]) begin
				d1_item.sum_word   = '0;
				d1_item.bad_offset = 1'b1;
			end else begin
				d1_item.sum_word = wide_res_q[d1_bank_q][WORD_BITS-1:0];
			end
		end else begin
			d1_item.sum_word = vld_q[{d1_bank_q, d1_idx_q[LANE_BITS-1:0]}] ? rd_d1 : '0;
		end
	end

	blwc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (d1_valid_q),
		.push_item (d1_item),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_item  (out_item),
		.level     (fifo_level)
	);

	assign m_tdata = out_item.sum_word;
	assign m_tuser = out_item.bad_offset;
	assign m_tlast = out_item.last_word;

endmodule

@@ hw/rtl/blwc_checker.sv @@
// ----------------------------------------------------------------------------
// blwc_checker
// port-level checks of the checksum block, bound to its top level
// ----------------------------------------------------------------------------
module blwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// an error result always closes its run
	a_bad_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("error item without last mark");

	// an error result carries no sum
	a_bad_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("error item with nonzero data");

	// a stalled item holds
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output item changed while stalled");

endmodule

bind byte_lane_and_wide_checksum blwc_checker u_blwc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
